FILE: rtl/core/epbc_pkg.sv
// Shared types and constants for the encoder PD brake controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package epbc_pkg;

  localparam int GainFracBits = 16;
  localparam int QDepth       = 2;
  localparam int QPtrW        = $clog2(QDepth);
  localparam int QCntW        = $clog2(QDepth + 1);
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTarget = 3'd0,
    CfgKp     = 3'd1,
    CfgKd     = 3'd2,
    CfgVLimit = 3'd3,
    CfgPeriod = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] target;
    logic [31:0]        kp;
    logic [31:0]        kd;
    logic [15:0]        v_limit;
    logic [15:0]        period;
  } cfg_t;

  typedef struct packed {
    logic [31:0] position;
  } q_entry_t;

  typedef enum logic [3:0] {
    SIdle,
    SErr,
    SDiff,
    SMag,
    SMul1,
    SMul2,
    SSum,
    SClamp,
    SDivInit,
    SDiv,
    SOut
  } back_state_e;

endpackage

FILE: rtl/core/epbc_front.sv
// Front end: takes input beats, keeps the encoder count and the tick timer,
// and pushes a position snapshot for each control update. Uses epbc_pkg.
`timescale 1ns / 1ps

module epbc_front import epbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        encb_i,
  input  logic [15:0] period_i,
  input  logic        q_full_i,
  output logic        push_o,
  output q_entry_t    push_data_o
);

  logic [31:0] enc_q, enc_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] elapsed_inc;
  logic        accept;

  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    enc_d               = enc_q;
    elapsed_d           = elapsed_q;
    push_o              = 1'b0;
    push_data_o.position = enc_q;
    if (accept) begin
      if (!kind_i) begin
        enc_d = encb_i ? enc_q - 32'd1 : enc_q + 32'd1;
      end else if (elapsed_inc >= period_i) begin
        elapsed_d = '0;
        push_o    = 1'b1;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q     <= '0;
      elapsed_q <= '0;
    end else begin
      enc_q     <= enc_d;
      elapsed_q <= elapsed_d;
    end
  end

  a_push_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (accept && kind_i && elapsed_d == 16'd0))
    else $error("update pushed without an accepted tick");

endmodule

FILE: rtl/core/epbc_queue.sv
// Short queue of position snapshots between front and back end.
// Depth from epbc_pkg.
`timescale 1ns / 1ps

module epbc_queue import epbc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_entry_t pop_data_o,
  output logic     full_o,
  output logic     empty_o
);

  q_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wptr_q, rptr_q;
  logic [QCntW-1:0]     cnt_q;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

FILE: rtl/core/epbc_back.sv
// Back end: sequencer for one PD update with a shared 32x32 multiplier,
// clamp, and a bit-serial duty divider; holds the result beat. Uses epbc_pkg.
`timescale 1ns / 1ps

module epbc_back import epbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_empty_i,
  input  q_entry_t    q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_reverse_o,
  output logic [7:0]  out_duty_o,
  output logic [31:0] out_pos_o,
  output logic [31:0] out_err_o
);

  localparam int IntW = 64 - GainFracBits;

  back_state_e state_q, state_d;

  logic [31:0]        pos_q;
  logic signed [31:0] err_q, last_err_q;
  logic signed [32:0] diff_q;
  logic [31:0]        err_mag_q, diff_mag_q;
  logic               n1_q, n2_q, neg_q;
  logic [63:0]        p1_q, p2_q;
  logic [64:0]        sum_q;
  logic [15:0]        q_q;
  logic [23:0]        dvd;
  logic [15:0]        rem_q;
  logic [7:0]         low_q, quo_q;
  logic [2:0]         cnt_q;
  logic               out_valid_q, out_rev_q;
  logic [7:0]         out_duty_q;
  logic [31:0]        out_pos_q, out_err_q;

  logic signed [32:0] err_wide;
  logic signed [31:0] err_sat;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [IntW:0]      q_wide;
  logic [15:0]        q_sel;
  logic [16:0]        div_t;
  logic               div_ge;
  logic               load_out;

  // saturated error
  assign err_wide = {cfg_i.target[31], cfg_i.target} - {pos_q[31], pos_q};
  always_comb begin
    if (err_wide[32] != err_wide[31]) begin
      err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      err_sat = err_wide[31:0];
    end
  end

  // shared multiplier
  assign mul_a = (state_q == SMul1) ? cfg_i.kp : cfg_i.kd;
  assign mul_b = (state_q == SMul1) ? err_mag_q : diff_mag_q;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // floor of the shift on a signed sum is the ceiling on its magnitude
  always_comb begin
    q_wide = {1'b0, sum_q[63:GainFracBits]}
           + (IntW + 1)'(neg_q && (sum_q[GainFracBits-1:0] != '0));
    if (sum_q[64] || q_wide > (IntW + 1)'(cfg_i.v_limit)) begin
      q_sel = cfg_i.v_limit;
    end else begin
      q_sel = q_wide[15:0];
    end
  end

  assign dvd    = {q_q, 8'd0} - {8'd0, q_q};
  assign div_t  = {rem_q, low_q[7]};
  assign div_ge = (cfg_i.v_limit != '0) && (div_t >= {1'b0, cfg_i.v_limit});

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = SErr;
        end
      end
      SErr:     state_d = SDiff;
      SDiff:    state_d = SMag;
      SMag:     state_d = SMul1;
      SMul1:    state_d = SMul2;
      SMul2:    state_d = SSum;
      SSum:     state_d = SClamp;
      SClamp:   state_d = SDivInit;
      SDivInit: state_d = SDiv;
      SDiv: begin
        if (cnt_q == 3'd7) begin
          state_d = SOut;
        end
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SDiff) begin
        last_err_q <= err_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        pos_q <= q_data_i.position;
      end
      SErr: begin
        err_q <= err_sat;
      end
      SDiff: begin
        diff_q <= {err_q[31], err_q} - {last_err_q[31], last_err_q};
      end
      SMag: begin
        err_mag_q  <= err_q[31] ? 32'(-err_q) : 32'(err_q);
        diff_mag_q <= diff_q[32] ? 32'(-diff_q) : diff_q[31:0];
        n1_q       <= err_q[31];
        n2_q       <= diff_q[32];
      end
      SMul1: begin
        p1_q <= mul_p;
      end
      SMul2: begin
        p2_q <= mul_p;
      end
      SSum: begin
        if (n1_q == n2_q) begin
          sum_q <= {1'b0, p1_q} + {1'b0, p2_q};
          neg_q <= n1_q;
        end else if (p1_q >= p2_q) begin
          sum_q <= {1'b0, p1_q - p2_q};
          neg_q <= n1_q;
        end else begin
          sum_q <= {1'b0, p2_q - p1_q};
          neg_q <= n2_q;
        end
      end
      SClamp: begin
        q_q   <= q_sel;
        neg_q <= neg_q && (q_sel != '0);
      end
      SDivInit: begin
        rem_q <= dvd[23:8];
        low_q <= dvd[7:0];
        cnt_q <= '0;
      end
      SDiv: begin
        rem_q <= div_ge ? 16'(div_t - {1'b0, cfg_i.v_limit}) : div_t[15:0];
        low_q <= {low_q[6:0], 1'b0};
        quo_q <= {quo_q[6:0], div_ge};
        cnt_q <= cnt_q + 3'd1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_rev_q  <= neg_q;
      out_duty_q <= quo_q;
      out_pos_q  <= pos_q;
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_reverse_o = out_rev_q;
  assign out_duty_o    = out_duty_q;
  assign out_pos_o     = out_pos_q;
  assign out_err_o     = out_err_q;

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDivInit) |-> (q_q <= cfg_i.v_limit))
    else $error("clamped output above limit");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDiv && cfg_i.v_limit != '0) |-> (rem_q < cfg_i.v_limit))
    else $error("divider remainder out of range");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == SOut))
    else $error("result beat raised outside the output step");

endmodule

FILE: rtl/core/encoder_pd_brake_controller.sv
// Encoder edge counter with a periodic PD position update. An encoder beat
// or a tick is taken while the snapshot queue (two entries) has room. Each
// update runs in the back-end sequencer from queue pop to result beat, with
// two passes through one shared 32x32 multiplier and eight steps of the
// bit-serial duty divider. A result beat waits in an output register, so the
// front keeps taking beats meanwhile while the queue has room.
// Depends on epbc_pkg, epbc_front, epbc_queue and epbc_back.
`timescale 1ns / 1ps

module encoder_pd_brake_controller import epbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] encb_level, [7:1] zero
  input  logic [0:0]          s_axis_tuser,  // [0] kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [79:0]         m_axis_tdata,  // [0] drive_reverse, [8:1] pwm_duty,
                                             // [40:9] position_counts,
                                             // [72:41] error_counts, [79:73] zero
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  q_entry_t push_data, pop_data;
  logic     push, pop, q_full, q_empty;
  logic     out_rev;
  logic [7:0]  out_duty;
  logic [31:0] out_pos, out_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target  <= '0;
      cfg_q.kp      <= 32'd65536;
      cfg_q.kd      <= '0;
      cfg_q.v_limit <= 16'd12000;
      cfg_q.period  <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTarget: cfg_q.target  <= cfg_data_i;
        CfgKp:     cfg_q.kp      <= cfg_data_i;
        CfgKd:     cfg_q.kd      <= cfg_data_i;
        CfgVLimit: cfg_q.v_limit <= cfg_data_i[15:0];
        CfgPeriod: cfg_q.period  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  epbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser[0]),
    .encb_i      (s_axis_tdata[0]),
    .period_i    (cfg_q.period),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  epbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  epbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_reverse_o (out_rev),
    .out_duty_o    (out_duty),
    .out_pos_o     (out_pos),
    .out_err_o     (out_err)
  );

  assign m_axis_tdata = {7'd0, out_err, out_pos, out_duty, out_rev};

endmodule

FILE: tb/sv/encoder_pd_brake_controller_tb.sv
// Self-checking bench for encoder_pd_brake_controller: directed table, then random phases.
// Predicts each PD update from a mirror of the counters and registers. Depends on epbc_pkg.
`timescale 1ns / 1ps

module encoder_pd_brake_controller_tb;
  import epbc_pkg::*;

  localparam logic KindEdge = 1'b0;
  localparam logic KindTick = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam int     CycleLimit   = 400000;
  localparam int     SettleCycles = 40;
  localparam longint ErrMax       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint ErrMin       = -64'sh0000_0000_8000_0000;

  // field order matches m_axis_tdata from bit 72 down
  typedef struct packed {
    logic [31:0] err;
    logic [31:0] pos;
    logic [7:0]  duty;
    logic        rev;
  } update_t;

  typedef enum logic {RowBeat, RowCfg} row_op_e;

  typedef struct packed {
    row_op_e            op;
    logic               kind;
    logic               encb;
    int                 reps;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
    logic               typed;
    update_t            want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [0] encb_level, [7:1] zero
  logic [0:0]          s_axis_tuser;   // [0] kind
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [79:0]         m_axis_tdata;   // [0] drive_reverse, [8:1] pwm_duty,
                                       // [40:9] position_counts, [72:41] error_counts
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // mirror of registers and counters
  logic signed [31:0] tgt_m;
  logic signed [31:0] enc_pos;
  logic signed [31:0] prev_err;
  logic [31:0]        kp_m;
  logic [31:0]        kd_m;
  logic [15:0]        vlim_m;
  logic [15:0]        period_m;
  logic [15:0]        ms_count;

  update_t update_q[$];
  int      fail_cnt  = 0;
  int      cycle_cnt = 0;
  bit      idle_en   = 1'b1;
  bit      stall_en  = 1'b1;

  encoder_pd_brake_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic step_controller(input logic kind, input logic encb,
                                 output logic fired, output update_t res);
    longint      err;
    longint      diff;
    logic [63:0] mag_e;
    logic [63:0] mag_d;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] lo;
    logic [63:0] q;
    logic [63:0] duty;
    logic        n1;
    logic        n2;
    logic        neg;
    logic        carry;
    fired = 1'b0;
    res   = '0;
    if (kind == KindEdge) begin
      enc_pos = encb ? enc_pos - 32'sd1 : enc_pos + 32'sd1;
      return;
    end
    if (ms_count != 16'hFFFF) ms_count++;
    if (ms_count < period_m) return;
    ms_count = '0;
    err = longint'(tgt_m) - longint'(enc_pos);
    if (err > ErrMax) err = ErrMax;
    if (err < ErrMin) err = ErrMin;
    diff  = err - longint'(prev_err);
    n1    = err < 0;
    n2    = diff < 0;
    mag_e = n1 ? -err : err;
    mag_d = n2 ? -diff : diff;
    p1    = mag_e * {32'd0, kp_m};
    p2    = mag_d * {32'd0, kd_m};
    carry = 1'b0;
    if (n1 == n2) begin
      {carry, lo} = {1'b0, p1} + {1'b0, p2};
      neg = n1;
    end else if (p1 >= p2) begin
      lo  = p1 - p2;
      neg = n1;
    end else begin
      lo  = p2 - p1;
      neg = n2;
    end
    if (lo == 0 && !carry) neg = 1'b0;
    if (carry) begin
      q = {48'd0, vlim_m};
    end else begin
      // shift floors, so a negative sum with a fraction gains one in magnitude
      q = lo >> GainFracBits;
      if (neg && lo[GainFracBits-1:0] != 0) q++;
      if (q > vlim_m) q = {48'd0, vlim_m};
    end
    if (q == 0) neg = 1'b0;
    duty = (vlim_m == 0) ? 64'd0 : q * 255 / vlim_m;
    if (duty > 255) duty = 255;
    res.rev  = neg;
    res.duty = duty[7:0];
    res.pos  = enc_pos;
    res.err  = err[31:0];
    prev_err = err[31:0];
    fired    = 1'b1;
  endtask

  // entered and left at a falling edge
  task automatic send_beat(input logic kind, input logic encb,
                           input logic typed, input update_t want);
    logic    fired;
    update_t res;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, encb};
    do @(posedge clk_i); while (!s_axis_tready);
    step_controller(kind, encb, fired, res);
    if (fired) update_q.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic drain_updates(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (update_q.size() != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CfgTarget: tgt_m    = data;
      CfgKp:     kp_m     = data;
      CfgKd:     kd_m     = data;
      CfgVLimit: vlim_m   = data[15:0];
      CfgPeriod: period_m = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return enc_pos + $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  task automatic run_phase(input int n_items, input logic [15:0] period, input bit hold_mid);
    int          tick_pct;
    int          down_pct;
    logic [15:0] vlim;
    drain_updates(SettleCycles);
    case ($urandom_range(0, 3))
      0:       vlim = 16'd1;
      1:       vlim = 16'hFFFF;
      2:       vlim = 16'd12000;
      default: vlim = 16'($urandom_range(1, 65535));
    endcase
    write_reg(CfgTarget, pick_target());
    write_reg(CfgKp, pick_gain());
    write_reg(CfgKd, pick_gain());
    write_reg(CfgVLimit, {16'($urandom), vlim});
    write_reg(CfgPeriod, {16'($urandom), period});
    tick_pct = $urandom_range(25, 60);
    down_pct = $urandom_range(20, 80);
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 2) drain_updates(0);
      send_beat($urandom_range(0, 99) < tick_pct ? KindTick : KindEdge,
                $urandom_range(0, 99) < down_pct, 1'b0, '0);
    end
  endtask

  function automatic row_t beat_row(input logic kind, input logic encb, input int reps);
    row_t r;
    r      = '0;
    r.op   = RowBeat;
    r.kind = kind;
    r.encb = encb;
    r.reps = reps;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    row_t r;
    r      = '0;
    r.op   = RowCfg;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t want_row(input logic rev, input logic [7:0] duty,
                                    input logic [31:0] pos, input logic [31:0] err);
    row_t r;
    r          = beat_row(KindTick, 1'b0, 1);
    r.typed    = 1'b1;
    r.want.rev = rev;
    r.want.duty = duty;
    r.want.pos = pos;
    r.want.err = err;
    return r;
  endfunction

  initial begin : result_stall
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    update_t got;
    update_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[72:0];
      if (update_q.size() == 0) begin
        $error("result beat with no update pending: %h", got);
        fail_cnt++;
      end else begin
        want = update_q.pop_front();
        if (got.rev !== want.rev) begin
          $error("drive_reverse: expected %0d, actual %0d", want.rev, got.rev);
          fail_cnt++;
        end
        if (got.duty !== want.duty) begin
          $error("pwm_duty: expected %0d, actual %0d", want.duty, got.duty);
          fail_cnt++;
        end
        if (got.pos !== want.pos) begin
          $error("position_counts: expected %0d, actual %0d",
                 $signed(want.pos), $signed(got.pos));
          fail_cnt++;
        end
        if (got.err !== want.err) begin
          $error("error_counts: expected %0d, actual %0d",
                 $signed(want.err), $signed(got.err));
          fail_cnt++;
        end
      end
    end
  end

  initial begin : main
    row_t plan[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    tgt_m         = '0;
    kp_m          = 32'd65536;
    kd_m          = '0;
    vlim_m        = 16'd12000;
    period_m      = 16'd10;
    enc_pos       = '0;
    prev_err      = '0;
    ms_count      = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: period of ten ticks, unit kp
    plan.push_back(beat_row(KindEdge, 1'b0, 1));
    plan.push_back(beat_row(KindEdge, 1'b1, 2));
    plan.push_back(beat_row(KindTick, 1'b1, 9));
    plan.push_back(want_row(1'b0, 8'd0, 32'hFFFF_FFFF, 32'd1));
    // upper bits of a 16-bit register are dropped
    plan.push_back(cfg_row(CfgPeriod, 32'hABCD_0001));
    // error saturates both ways
    plan.push_back(cfg_row(CfgTarget, 32'h7FFF_FFFF));
    plan.push_back(want_row(1'b0, 8'd255, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    plan.push_back(beat_row(KindEdge, 1'b0, 2));
    plan.push_back(cfg_row(CfgTarget, 32'h8000_0000));
    plan.push_back(want_row(1'b1, 8'd255, 32'd1, 32'h8000_0000));
    // PD sum beyond 64 bits
    plan.push_back(cfg_row(CfgKp, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CfgKd, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CfgTarget, 32'h7FFF_FFFF));
    plan.push_back(want_row(1'b0, 8'd255, 32'd1, 32'h7FFF_FFFE));
    // zero limit, then widest limit
    plan.push_back(cfg_row(CfgVLimit, 32'hFFFF_0000));
    plan.push_back(want_row(1'b0, 8'd0, 32'd1, 32'h7FFF_FFFE));
    plan.push_back(cfg_row(CfgVLimit, 32'h0000_FFFF));
    plan.push_back(want_row(1'b0, 8'd255, 32'd1, 32'h7FFF_FFFE));
    // writes to unused indexes change nothing
    plan.push_back(cfg_row(CfgSpareLo, 32'h0000_0000));
    plan.push_back(cfg_row(CfgSpareHi, 32'hFFFF_FFFF));
    plan.push_back(beat_row(KindTick, 1'b0, 1));
    plan.push_back(cfg_row(CfgKd, 32'h0000_0000));
    plan.push_back(cfg_row(CfgKp, 32'h0000_0000));
    plan.push_back(want_row(1'b0, 8'd0, 32'd1, 32'h7FFF_FFFE));
    // half gain on a negative error: floor of the shift
    plan.push_back(cfg_row(CfgKp, 32'h0000_8000));
    plan.push_back(cfg_row(CfgTarget, 32'h0000_0000));
    plan.push_back(beat_row(KindTick, 1'b0, 1));
    plan.push_back(cfg_row(CfgVLimit, 32'h0000_0001));
    plan.push_back(beat_row(KindTick, 1'b1, 1));
    // derivative term with both signs against the proportional one
    plan.push_back(cfg_row(CfgKd, 32'h0001_0000));
    plan.push_back(beat_row(KindEdge, 1'b0, 3));
    plan.push_back(beat_row(KindTick, 1'b0, 1));
    plan.push_back(beat_row(KindEdge, 1'b1, 6));
    plan.push_back(beat_row(KindTick, 1'b0, 1));
    // period of zero updates on every tick
    plan.push_back(cfg_row(CfgVLimit, 32'h0000_0BB8));
    plan.push_back(cfg_row(CfgPeriod, 32'h0000_0000));
    plan.push_back(beat_row(KindTick, 1'b0, 3));

    foreach (plan[r]) begin
      if (plan[r].op == RowCfg) begin
        drain_updates(SettleCycles);
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        repeat (plan[r].reps)
          send_beat(plan[r].kind, plan[r].encb, plan[r].typed, plan[r].want);
      end
    end

    for (int p = 0; p < 7; p++)
      run_phase(180, (p == 0) ? 16'd1 : 16'($urandom_range(1, 12)), p == 2);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    run_phase(150, 16'd3, 1'b0);

    drain_updates(SettleCycles);
    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/epbc_pkg.sv
rtl/core/epbc_front.sv
rtl/core/epbc_queue.sv
rtl/core/epbc_back.sv
rtl/core/encoder_pd_brake_controller.sv
tb/sv/encoder_pd_brake_controller_tb.sv
